// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL; all are clocked on i_clk and
// switched off while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property that must hold at every edge out of reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/flc_pkg.sv =====
package flc_pkg;

    localparam int SAMPLE_W = 16;
    localparam int PROD_W   = 32;
    localparam int ACC_W    = 40;
    localparam int CFG_W    = 6;
    localparam int IDX_W    = 5;

    localparam logic OP_TAP    = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    typedef struct packed {
        logic                       operation;
        logic [IDX_W-1:0]           tap_index;
        logic signed [SAMPLE_W-1:0] value;
        logic                       last_sample;
    } t_in_item;

    typedef struct packed {
        logic signed [ACC_W-1:0] result;
        logic                    last_result;
    } t_out_item;

    // Controls common to every cell of the row.
    typedef struct packed {
        logic shift;
        logic clear;
    } t_cell_ctl;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_HOLD
    } t_state;

endpackage

// ===== hw/rtl/flc_cell.sv =====
module flc_cell
    import flc_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_cell_ctl                  i_ctl,
    input  logic                       i_tap_we,
    input  logic signed [SAMPLE_W-1:0] i_tap,
    input  logic signed [SAMPLE_W-1:0] i_x,
    output logic signed [SAMPLE_W-1:0] o_x,
    input  logic                       i_en,
    input  logic                       i_tok,
    output logic                       o_tok,
    input  logic signed [ACC_W-1:0]    i_acc,
    output logic signed [ACC_W-1:0]    o_acc
);

    logic signed [SAMPLE_W-1:0] r_tap;
    logic signed [SAMPLE_W-1:0] r_w;
    logic signed [ACC_W-1:0]    r_acc;
    logic                       r_tok;
    logic signed [PROD_W-1:0]   prod;
    logic signed [ACC_W-1:0]    n_acc;

    assign prod  = r_tap * r_w;
    // Cells past the kernel length pass the partial sum unchanged.
    assign n_acc = i_en ? i_acc + ACC_W'(prod) : i_acc;

    always_ff @(posedge i_clk) begin
        if (i_tap_we) begin
            r_tap <= i_tap;
        end
        if (i_tok) begin
            r_acc <= n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w   <= '0;
            r_tok <= 1'b0;
        end else begin
            r_tok <= i_tok;
            if (i_ctl.clear) begin
                r_w <= '0;
            end else if (i_ctl.shift) begin
                r_w <= i_x;
            end
        end
    end

    assign o_x   = r_w;
    assign o_tok = r_tok;
    assign o_acc = r_acc;

endmodule

// ===== hw/rtl/full_linear_convolution.sv =====
// Channel | Direction | Handshake                     | Payload
// in      | into      | i_in_valid / o_in_stall       | i_in_data  (t_in_item)
// out     | out of    | o_out_valid / i_out_stall     | o_out_data (t_out_item)
// cfg     | into      | i_cfg_we                      | i_cfg_data (tap_count)
//
// A tap load is taken in idle and writes its cell. For a sample, a walk starts, the
// partial sum walks the row one cell a cycle, and the output register loads before the
// next input transfer. A last sample adds kernel length - 1 tail results, each loaded
// as the next zero shifts in while a result loads.
// Reset (synchronous, i_rst_n low) zeroes the sample window and sets tap_count to 1;
// taps stay unknown until loaded. A stalled output holds the sum in the row until free.
module full_linear_convolution
    import flc_pkg::*;
#(
    parameter int MAX_TAPS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_in_item   i_in_data,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out_item  o_out_data,
    input  logic       i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_data
);

`include "assert_macros.svh"

    localparam logic [CFG_W-1:0] MAX_LEN = CFG_W'(MAX_TAPS);

    // Control state.
    t_state              r_state, n_state;
    logic                r_start, n_start;
    logic [IDX_W-1:0]    r_tail, n_tail;
    logic                r_last_seq, n_last_seq;
    logic [CFG_W-1:0]    r_tap_count;
    logic                r_out_valid;
    t_out_item           r_out;

    // Row of cells.
    logic signed [SAMPLE_W-1:0] w_x   [MAX_TAPS];
    logic signed [ACC_W-1:0]    w_acc [MAX_TAPS];
    logic [MAX_TAPS-1:0]        w_tok;
    logic [MAX_TAPS-1:0]        tap_we;
    logic [MAX_TAPS-1:0]        en;
    t_cell_ctl                  ctl;
    logic signed [SAMPLE_W-1:0] shift_in;

    logic [CFG_W-1:0] len;
    logic             in_take;
    logic             sample_take;
    logic             out_free;
    logic             tok_last;
    logic             take;

    // Kernel length: zero acts as one, anything past the row acts as the row.
    always_comb begin
        if (r_tap_count == '0) begin
            len = CFG_W'(1);
        end else if (r_tap_count > MAX_LEN) begin
            len = MAX_LEN;
        end else begin
            len = r_tap_count;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_take     = i_in_valid && (r_state == S_IDLE);
    assign sample_take = in_take && (i_in_data.operation == OP_SAMPLE);
    assign out_free    = !r_out_valid || !i_out_stall;
    assign tok_last    = w_tok[MAX_TAPS-1];
    // Transfer the finished sum into the output register.
    assign take        = ((r_state == S_RUN && tok_last) || r_state == S_HOLD) && out_free;

    always_comb begin
        n_state    = r_state;
        n_start    = 1'b0;
        n_tail     = r_tail;
        n_last_seq = r_last_seq;
        ctl.shift  = 1'b0;
        ctl.clear  = 1'b0;
        shift_in   = '0;

        unique case (r_state)
            S_IDLE: begin
                if (sample_take) begin
                    // Shift the sample into the window and start a walk.
                    ctl.shift  = 1'b1;
                    shift_in   = i_in_data.value;
                    n_start    = 1'b1;
                    n_last_seq = i_in_data.last_sample;
                    n_tail     = i_in_data.last_sample ? IDX_W'(len - CFG_W'(1)) : '0;
                    n_state    = S_RUN;
                end
            end
            S_RUN: begin
                if (tok_last && !out_free) begin
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (take) begin
            if (r_tail != '0) begin
                // Tail: feed a zero sample and walk again.
                ctl.shift = 1'b1;
                shift_in  = '0;
                n_start   = 1'b1;
                n_tail    = r_tail - IDX_W'(1);
                n_state   = S_RUN;
            end else begin
                n_state = S_IDLE;
                if (r_last_seq) begin
                    // End of sequence: drop the history.
                    ctl.clear  = 1'b1;
                    n_last_seq = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_start     <= 1'b0;
            r_tail      <= '0;
            r_last_seq  <= 1'b0;
            r_tap_count <= CFG_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_start    <= n_start;
            r_tail     <= n_tail;
            r_last_seq <= n_last_seq;
            if (i_cfg_we) begin
                r_tap_count <= i_cfg_data;
            end
            if (take) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out.result      <= w_acc[MAX_TAPS-1];
            r_out.last_result <= r_last_seq && (r_tail == '0);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    genvar k;
    generate
        for (k = 0; k < MAX_TAPS; k++) begin : g_cell
            // Indexes past the row match no cell, so such tap loads drop.
            assign tap_we[k] = in_take && (i_in_data.operation == OP_TAP)
                               && (i_in_data.tap_index == IDX_W'(k));
            assign en[k]     = (CFG_W'(k) < len);

            if (k == 0) begin : g_head
                flc_cell u_cell (
                    .i_clk    (i_clk),
                    .i_rst_n  (i_rst_n),
                    .i_ctl    (ctl),
                    .i_tap_we (tap_we[k]),
                    .i_tap    (i_in_data.value),
                    .i_x      (shift_in),
                    .o_x      (w_x[k]),
                    .i_en     (en[k]),
                    .i_tok    (r_start),
                    .o_tok    (w_tok[k]),
                    .i_acc    ('0),
                    .o_acc    (w_acc[k])
                );
            end else begin : g_body
                flc_cell u_cell (
                    .i_clk    (i_clk),
                    .i_rst_n  (i_rst_n),
                    .i_ctl    (ctl),
                    .i_tap_we (tap_we[k]),
                    .i_tap    (i_in_data.value),
                    .i_x      (w_x[k-1]),
                    .o_x      (w_x[k]),
                    .i_en     (en[k]),
                    .i_tok    (w_tok[k-1]),
                    .o_tok    (w_tok[k]),
                    .i_acc    (w_acc[k-1]),
                    .o_acc    (w_acc[k])
                );
            end
        end
    endgenerate

    // At most one partial sum walks the row.
    `ASSERT_ALWAYS(a_one_walk, $onehot0({w_tok, r_start}), "more than one walk in the row")
    // Nothing walks while waiting for input.
    `ASSERT_IMPL(a_idle_quiet, r_state == S_IDLE, (w_tok == '0) && !r_start, "walk while idle")
    // Tail results only follow a last sample.
    `ASSERT_IMPL(a_tail_last, r_tail != '0, r_last_seq, "tail count without last sample")
    // An accepted sample starts a walk next cycle.
    `ASSERT_NEXT(a_sample_start, sample_take, r_start, "sample did not start a walk")

endmodule

// ===== tb/full_linear_convolution_tb.sv =====
module full_linear_convolution_tb;
    import flc_pkg::*;

    localparam int NUM_TAPS = 32;
    // One result walks the whole tap row, plus start, output register and margin.
    localparam int RESULT_CYCLES = NUM_TAPS + 4;

    logic i_clk = 1'b0;
    logic rst_n = 1'b0;

    logic            in_valid = 1'b0;
    t_in_item        in_data  = '0;
    logic            in_stall;
    logic            out_valid;
    logic            out_stall = 1'b0;
    t_out_item       out_data;
    logic            cfg_we   = 1'b0;
    logic [CFG_W-1:0] cfg_data = '0;

    // Idle and stall rates in percent, changed per test phase.
    int send_idle_pct = 10;
    int out_stall_pct = 53;

    // Shadow of the block: tap store, sample window (newest first), kernel length.
    logic signed [SAMPLE_W-1:0] tap_shadow [NUM_TAPS];
    logic signed [SAMPLE_W-1:0] window [NUM_TAPS-1];
    logic [CFG_W-1:0]           tap_count_shadow = 6'd1;
    t_out_item                  pending_outputs [$];

    int items_sent = 0;
    int outputs_checked = 0;
    int cfg_writes = 0;
    int mismatches = 0;
    int last_flushes = 0;

    full_linear_convolution #(
        .MAX_TAPS(NUM_TAPS)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        for (int i = 0; i < NUM_TAPS; i++) tap_shadow[i] = '0;
        for (int i = 0; i < NUM_TAPS - 1; i++) window[i] = '0;
    end

    // Kernel length as the block sees it: zero acts as one, big values clamp.
    function automatic int unsigned kernel_len();
        if (tap_count_shadow == 0) return 1;
        if (tap_count_shadow > NUM_TAPS) return NUM_TAPS;
        return int'(tap_count_shadow);
    endfunction

    // Shift one sample into the window and return the convolution sum.
    function automatic logic signed [ACC_W-1:0] shift_and_accumulate(
        input logic signed [SAMPLE_W-1:0] sample
    );
        logic signed [ACC_W-1:0] acc;
        int unsigned len;
        len = kernel_len();
        acc = tap_shadow[0] * sample;
        for (int k = 1; k < len; k++) acc = acc + tap_shadow[k] * window[k-1];
        for (int k = NUM_TAPS - 2; k > 0; k--) window[k] = window[k-1];
        window[0] = sample;
        return acc;
    endfunction

    // Queue the outputs that one accepted transfer causes.
    function automatic void predict_outputs(input t_in_item item);
        t_out_item o;
        int unsigned len;
        if (item.operation == OP_TAP) begin
            tap_shadow[item.tap_index] = item.value;
            return;
        end
        len = kernel_len();
        o.result      = shift_and_accumulate(item.value);
        o.last_result = item.last_sample && (len == 1);
        pending_outputs.push_back(o);
        if (item.last_sample) begin
            // Tail flush: zeros shifted in, final one marked last.
            for (int t = 1; t < len; t++) begin
                o.result      = shift_and_accumulate('0);
                o.last_result = (t == len - 1);
                pending_outputs.push_back(o);
            end
            for (int k = 0; k < NUM_TAPS - 1; k++) window[k] = '0;
            last_flushes++;
        end
    endfunction

    // Drive one transfer, with random idle cycles ahead of it; valid stays
    // high afterwards, until the next call or wait_idle drives it again.
    task automatic send_item(input t_in_item item);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        predict_outputs(item);
        items_sent++;
    endtask

    task automatic send_tap(input int idx, input logic signed [SAMPLE_W-1:0] v,
                            input logic flag);
        t_in_item item;
        item.operation   = OP_TAP;
        item.tap_index   = idx[IDX_W-1:0];
        item.value       = v;
        item.last_sample = flag;
        send_item(item);
    endtask

    task automatic send_sample(input logic signed [SAMPLE_W-1:0] v, input logic last,
                               input int idx);
        t_in_item item;
        item.operation   = OP_SAMPLE;
        item.tap_index   = idx[IDX_W-1:0];
        item.value       = v;
        item.last_sample = last;
        send_item(item);
    endtask

    // Drop valid, wait for every queued output, then let the row settle.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_outputs.size() != 0) @(posedge i_clk);
        repeat (RESULT_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_tap_count(input logic [CFG_W-1:0] v);
        wait_idle();
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        tap_count_shadow = v;
        cfg_writes++;
    endtask

    function automatic logic signed [SAMPLE_W-1:0] pick_value();
        case ($urandom_range(7))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return '0;
            3: return -16'sd1;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // Mostly short kernels keep tail flushes cheap; the extremes come now and then.
    function automatic logic [CFG_W-1:0] pick_tap_count();
        case ($urandom_range(9))
            0: return 6'd0;
            1: return 6'd32;
            2: return 6'd63;
            3: return CFG_W'($urandom_range(63));
            default: return CFG_W'($urandom_range(1, 6));
        endcase
    endfunction

    // Tap count zero acts as one; one tap gives a single last output.
    task automatic test_single_tap();
        write_tap_count(6'd0);
        send_tap(0, 16'sh8000, 1'b1);     // last flag on a tap load is ignored
        send_sample(16'sh8000, 1'b0, 31); // largest positive product
        send_sample(16'sh7fff, 1'b1, 0);
        write_tap_count(6'd1);
        send_sample(16'sh0001, 1'b1, 0);
    endtask

    // Extreme samples against extreme taps, with a tail flush.
    task automatic test_value_extremes();
        write_tap_count(6'd3);
        send_tap(1, 16'sh7fff, 1'b0);
        send_tap(2, -16'sd1, 1'b0);
        send_sample(16'sh8000, 1'b0, 0);
        send_sample(16'sh7fff, 1'b0, 0);
        send_sample(16'sh0001, 1'b0, 0);
        send_sample('0, 1'b1, 0);
    endtask

    // Change length and taps in the middle of a sequence; history carries over.
    task automatic test_mid_sequence_change();
        write_tap_count(6'd2);
        send_sample(16'sd100, 1'b0, 0);
        send_sample(-16'sd200, 1'b0, 0);
        write_tap_count(6'd3);
        send_tap(0, 16'sd12345, 1'b0);
        send_sample(-16'sd1, 1'b0, 0);
        send_sample(16'sh7fff, 1'b1, 0);
    endtask

    // Mostly well-formed sequences with random content, some tap rewrites,
    // some sequences left open, and length changes between them.
    task automatic test_random_stream(input int n_items, input int idle_pct,
                                      input int stall_pct);
        int start;
        int n;
        start = items_sent;
        send_idle_pct = idle_pct;
        out_stall_pct = stall_pct;
        while (items_sent - start < n_items) begin
            case ($urandom_range(19))
                0, 1, 2: write_tap_count(pick_tap_count());
                3, 4, 5: begin
                    n = $urandom_range(1, 3);
                    repeat (n) send_tap($urandom_range(NUM_TAPS - 1), pick_value(),
                                        1'($urandom_range(1)));
                end
                default: begin
                    n = $urandom_range(1, 8);
                    for (int i = 0; i < n; i++) begin
                        // Close the sequence on its last sample, except now and then.
                        send_sample(pick_value(),
                                    (i == n - 1) && ($urandom_range(9) != 0),
                                    $urandom_range(NUM_TAPS - 1));
                    end
                end
            endcase
        end
    endtask

    task automatic load_every_tap();
        for (int i = 0; i < NUM_TAPS; i++) send_tap(i, pick_value(), 1'($urandom_range(1)));
    endtask

    // Check each output transfer against the oldest expectation.
    always @(posedge i_clk) begin : check_outputs
        t_out_item want;
        out_stall <= ($urandom_range(99) < out_stall_pct);
        if (rst_n && out_valid && !out_stall) begin
            outputs_checked++;
            if (pending_outputs.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected output %0d: result %0d last %0b",
                             outputs_checked, out_data.result, out_data.last_result);
            end else begin
                want = pending_outputs.pop_front();
                if (out_data.result !== want.result ||
                    out_data.last_result !== want.last_result) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("output %0d: expected result %0d last %0b, got %0d last %0b",
                                 outputs_checked, want.result, want.last_result,
                                 out_data.result, out_data.last_result);
                end
            end
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        test_single_tap();
        test_value_extremes();
        test_mid_sequence_change();
        load_every_tap();
        test_random_stream(35, 10, 53);
        test_random_stream(35, 53, 10);
        test_random_stream(35, 0, 0);

        wait_idle();
        $display("Sent %0d transfers, %0d tail flushes, %0d tap count writes;",
                 items_sent, last_flushes, cfg_writes);
        $display("checked %0d outputs, %0d mismatches.", outputs_checked, mismatches);
        if (mismatches == 0 && pending_outputs.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #12_000_000;
        $display("timeout with %0d outputs still expected", pending_outputs.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
